/* src/fbt_pkg.sv */
// Shared types, constants and helpers of the flow table.
`timescale 1ns / 1ps
package fbt_pkg;

  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF = 4;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_BITS = 8;
  localparam int DIV_CYCLES = 32 / DIV_BITS;

  localparam logic [8:0] BUCKET_COUNT_RST = 9'd256;
  localparam logic [31:0] FLOW_TIMEOUT_RST = 32'd60;

  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_FLOW_TIMEOUT = 1'b1;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_EXPIRED = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_SWEEP = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] flow_key;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] byte_count;
    logic [31:0] time_now;
    logic [7:0]  sweep_bucket;
  } fbt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  rec_protocol;
    logic [31:0] rec_source_address;
    logic [31:0] rec_dest_address;
    logic [15:0] rec_source_port;
    logic [15:0] rec_dest_port;
    logic [31:0] rec_packets;
    logic [31:0] rec_bytes;
    logic        last_result;
  } fbt_out_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] first_time;
    logic [31:0] last_time;
  } fbt_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_EVAL,
    B_FIN
  } back_state_t;

  function automatic fbt_out_t make_result(logic [2:0] st, fbt_entry_t e, logic has,
                                           logic last);
    fbt_out_t r;
    r.status = st;
    r.rec_protocol = has ? e.protocol : 8'd0;
    r.rec_source_address = has ? e.src_addr : 32'd0;
    r.rec_dest_address = has ? e.dst_addr : 32'd0;
    r.rec_source_port = has ? e.src_port : 16'd0;
    r.rec_dest_port = has ? e.dst_port : 16'd0;
    r.rec_packets = has ? e.packets : 32'd0;
    r.rec_bytes = has ? e.bytes : 32'd0;
    r.last_result = last;
    return r;
  endfunction

endpackage

/* src/fbt_front.sv */
// Front end: accepts transactions and works out the bucket of each.
`timescale 1ns / 1ps
module fbt_front import fbt_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbt_in_t                         in_data,
  input  logic [8:0]                      bucket_count,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [$bits(fbt_in_t)+BKT_W:0]  q_data
);

  localparam int STEP_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  front_state_t state, state_next;
  fbt_in_t item;
  logic [31:0] key, key_next;
  logic [8:0] rem, rem_next;
  logic [8:0] modulus, n_eff;
  logic [STEP_W-1:0] step;
  logic [BKT_W-1:0] bucket;
  logic in_range;
  logic accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    if (bucket_count == 9'd0) begin
      n_eff = 9'd1;
    end else if (32'(bucket_count) > 32'(BUCKETS)) begin
      n_eff = 9'(BUCKETS);
    end else begin
      n_eff = bucket_count;
    end
  end

  always_comb begin
    logic [9:0] r;
    logic [31:0] k;
    r = {1'b0, rem};
    k = key;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[8:0], k[31]};
      k = {k[30:0], 1'b0};
      if (r >= {1'b0, modulus}) begin
        r = r - {1'b0, modulus};
      end
    end
    rem_next = r[8:0];
    key_next = k;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.command == CMD_SWEEP) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (step == STEP_W'(DIV_CYCLES - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
    q_data = {in_range, bucket, item};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      key <= in_data.flow_key;
      rem <= 9'd0;
      modulus <= n_eff;
      step <= '0;
      if (in_data.command == CMD_SWEEP) begin
        bucket <= BKT_W'(in_data.sweep_bucket);
        in_range <= (32'(in_data.sweep_bucket) < 32'(BUCKETS));
      end else begin
        in_range <= 1'b1;
      end
    end else if (state == F_DIV) begin
      key <= key_next;
      rem <= rem_next;
      step <= step + 1'b1;
      bucket <= BKT_W'(rem_next);
    end
  end

endmodule

/* src/fbt_queue.sv */
// Short first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps
module fbt_queue import fbt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full = (count == CNT_QW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/fbt_back.sv */
// Back end: walks the ways of a bucket, updates the table and issues results.
`timescale 1ns / 1ps
module fbt_back import fbt_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS = WAYS_DEF,
  parameter int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  logic [$bits(fbt_in_t)+BKT_W:0]  q_data,
  input  logic [31:0]                     flow_timeout,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbt_out_t                        out_data
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MEM_DEPTH = BUCKETS * (2 ** WAY_W);

  back_state_t state, state_next;
  fbt_in_t job;
  logic [BKT_W-1:0] job_bucket;
  logic job_in_range;
  logic [WAY_W-1:0] way, free_way, wr_way;
  logic have_free;
  logic [CNT_W-1:0] cnt;
  logic pend_valid;
  fbt_out_t pend_rec;

  fbt_entry_t mem [MEM_DEPTH];
  logic [WAYS-1:0] vrow [BUCKETS];
  logic [WAYS-1:0] vbits, vrow_wr;
  logic init_busy;
  logic [BKT_W-1:0] init_idx;
  fbt_entry_t rd_data, upd, nw, wr_data;

  logic ev, last_way, hit, dur_over, idle_over, take, slot_free, stall;
  logic emit, mem_we, set_v, clr_v, step_way, grab_free, take_pend;
  fbt_out_t emit_data;

  assign slot_free = !out_valid || out_ready;
  assign ev = vbits[way];
  assign last_way = (way == WAY_W'(WAYS - 1));

  always_comb begin
    hit = ev && (rd_data.protocol == job.ip_protocol)
        && ((rd_data.src_addr == job.source_address && rd_data.dst_addr == job.dest_address)
         || (rd_data.src_addr == job.dest_address && rd_data.dst_addr == job.source_address))
        && ((rd_data.src_port == job.source_port && rd_data.dst_port == job.dest_port)
         || (rd_data.src_port == job.dest_port && rd_data.dst_port == job.source_port));
    dur_over = (rd_data.last_time >= rd_data.first_time)
        && ((rd_data.last_time - rd_data.first_time) > flow_timeout);
    idle_over = (job.time_now >= rd_data.last_time)
        && ((job.time_now - rd_data.last_time) > flow_timeout);
    take = ev && (dur_over || idle_over) && (cnt < CNT_W'(MAX_RESULTS));
    stall = take && pend_valid && !slot_free;

    upd = rd_data;
    upd.packets = rd_data.packets + 32'd1;
    upd.bytes = rd_data.bytes + job.byte_count;
    upd.last_time = job.time_now;

    nw.protocol = job.ip_protocol;
    nw.src_addr = job.source_address;
    nw.dst_addr = job.dest_address;
    nw.src_port = job.source_port;
    nw.dst_port = job.dest_port;
    nw.packets = 32'd1;
    nw.bytes = job.byte_count;
    nw.first_time = job.time_now;
    nw.last_time = job.time_now;
  end

  always_comb begin
    emit = 1'b0;
    emit_data = '0;
    mem_we = 1'b0;
    wr_way = way;
    wr_data = upd;
    set_v = 1'b0;
    clr_v = 1'b0;
    step_way = 1'b0;
    grab_free = 1'b0;
    take_pend = 1'b0;
    q_pop = (state == B_IDLE) && q_valid && !init_busy;
    unique case (state)
      B_EVAL: begin
        if (job.command == CMD_PACKET) begin
          if (slot_free) begin
            if (hit) begin
              mem_we = 1'b1;
              emit = 1'b1;
              emit_data = make_result(ST_UPDATED, upd, 1'b1, 1'b1);
            end else if (last_way) begin
              emit = 1'b1;
              if (have_free || !ev) begin
                mem_we = 1'b1;
                wr_way = have_free ? free_way : way;
                wr_data = nw;
                set_v = 1'b1;
                emit_data = make_result(ST_INSERTED, nw, 1'b1, 1'b1);
              end else begin
                emit_data = make_result(ST_DROPPED, nw, 1'b0, 1'b1);
              end
            end else begin
              grab_free = !ev && !have_free;
              step_way = 1'b1;
            end
          end
        end else if (!stall) begin
          if (take) begin
            clr_v = 1'b1;
            take_pend = 1'b1;
            if (pend_valid) begin
              emit = 1'b1;
              emit_data = pend_rec;
            end
          end
          step_way = !last_way;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pend_valid) begin
            emit_data = pend_rec;
            emit_data.last_result = 1'b1;
          end else begin
            emit_data = make_result(ST_NONE, rd_data, 1'b0, 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    vrow_wr = vbits;
    if (set_v) begin
      vrow_wr[wr_way] = 1'b1;
    end
    if (clr_v) begin
      vrow_wr[way] = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && !init_busy) begin
          state_next = (q_data[$bits(fbt_in_t)+BKT_W]) ? B_RD : B_FIN;
        end
      end
      B_RD: state_next = B_EVAL;
      B_EVAL: begin
        if (job.command == CMD_PACKET) begin
          if (slot_free) begin
            state_next = (hit || last_way) ? B_IDLE : B_RD;
          end
        end else if (!stall) begin
          state_next = last_way ? B_FIN : B_RD;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
      init_busy <= 1'b1;
      init_idx <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop || (state == B_FIN && slot_free)) begin
        pend_valid <= 1'b0;
      end else if (take_pend) begin
        pend_valid <= 1'b1;
      end
      if (init_busy) begin
        init_idx <= init_idx + 1'b1;
        if (init_idx == BKT_W'(BUCKETS - 1)) begin
          init_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
    if (q_pop) begin
      {job_in_range, job_bucket, job} <= q_data;
      way <= '0;
      have_free <= 1'b0;
      cnt <= '0;
    end else begin
      if (step_way) begin
        way <= way + 1'b1;
      end
      if (grab_free) begin
        have_free <= 1'b1;
        free_way <= way;
      end
      if (take_pend) begin
        pend_rec <= make_result(ST_EXPIRED, rd_data, 1'b1, 1'b0);
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init_busy) begin
      vrow[init_idx] <= '0;
    end else if (set_v || clr_v) begin
      vrow[job_bucket] <= vrow_wr;
    end
    if (state == B_RD) begin
      vbits <= vrow[job_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{job_bucket, wr_way}] <= wr_data;
    end
    if (state == B_RD) begin
      rd_data <= mem[{job_bucket, way}];
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> !pend_valid)
    else $error("Pending expiry record left over in idle state.");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RESULTS))
    else $error("Sweep emitted more records than allowed.");

  a_write_packet_only: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (job.command == CMD_PACKET && state == B_EVAL))
    else $error("Table written outside packet evaluation.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("Result register overwritten before it was taken.");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_RD) |-> job_in_range)
    else $error("Table read for an out-of-range sweep.");

endmodule

/* src/bidirectional_flow_table.sv */
// Top level of the bidirectional flow table with ageing.
`timescale 1ns / 1ps
// The front end reduces the key of a packet modulo the bucket count, eight bits a cycle,
// and the back end reads one way of the bucket from the single-port table memory and
// evaluates it in the next cycle, so the walk over the ways sets the rate. A two-entry
// queue lets the front end take the next transaction while the back end is busy, and
// results wait in an output register. After reset the valid bits are cleared by a pass
// over the buckets, one bucket a cycle, and the back end takes no transaction until that
// pass has ended.
module bidirectional_flow_table import fbt_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fbt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output fbt_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = $bits(fbt_in_t) + BKT_W + 1;

  logic [8:0] bucket_count;
  logic [31:0] flow_timeout;
  logic q_full, q_push, q_pop, q_valid;
  logic [QW-1:0] q_in, q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLOW_TIMEOUT) ? flow_timeout : {23'd0, bucket_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RST;
      flow_timeout <= FLOW_TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BUCKET_COUNT) begin
        bucket_count <= pwdata[8:0];
      end else begin
        flow_timeout <= pwdata;
      end
    end
  end

  fbt_front #(.BUCKETS(BUCKETS), .BKT_W(BKT_W)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .bucket_count(bucket_count),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  fbt_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
  );

  fbt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .BKT_W(BKT_W)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_out),
    .flow_timeout(flow_timeout),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
